/* src/si_pkg.sv */
`default_nettype none
package si_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 4;
   localparam int OUT_W      = 24;

   localparam int CW  = COORD_BITS;
   localparam int DFW = CW + 1;               // signed coordinate difference
   localparam int DW  = 2 * CW + 3;           // signed determinant
   localparam int DMW = DW - 1;               // determinant magnitude
   localparam int CAW = 2 * CW + 2;           // signed cross term of one segment
   localparam int NW  = 3 * CW + 3;           // signed numerator
   localparam int BW  = CW + DMW;             // bound times determinant
   localparam int QW  = OUT_W;                // quotient bits, one per cell
   localparam int MW  = NW - 1 + FRAC_BITS;   // scaled numerator magnitude
   localparam int RW  = (MW > DMW + QW) ? MW : DMW + QW;

   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OUTCOME_HIT      = 2'd0,
      OUTCOME_PARALLEL = 2'd1,
      OUTCOME_MISS     = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QW-1:0] quot;
      logic          neg;
      logic          ovf;
   } lane_type;

   typedef struct packed {
      logic          valid;
      outcome_type   outcome;
      logic [RW-1:0] dsh;
      lane_type      x;
      lane_type      y;
   } div_stage_type;

endpackage
`default_nettype wire

/* src/si_front.sv */
`default_nettype none
module si_front
   import si_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [CW-1:0]  x1,
   input  wire logic [CW-1:0]  y1,
   input  wire logic [CW-1:0]  x2,
   input  wire logic [CW-1:0]  y2,
   input  wire logic [CW-1:0]  x3,
   input  wire logic [CW-1:0]  y3,
   input  wire logic [CW-1:0]  x4,
   input  wire logic [CW-1:0]  y4,
   output div_stage_type       stage_out
);

   localparam int NS = 7;

   logic [NS-1:0] valid_ff;

   // stage 1: coordinates and differences
   logic [CW-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;
   logic signed [DFW-1:0] dax1_ff, day1_ff, dbx1_ff, dby1_ff;

   // bounds: lo/hi for a.x, b.x, a.y, b.y
   logic [CW-1:0] bnd_in [8];
   logic [CW-1:0] bnd2_ff [8], bnd3_ff [8], bnd4_ff [8], bnd5_ff [8], bnd6_ff [8];

   // stage 2: products
   logic signed [CAW-1:0] pd1_ff, pd2_ff;
   logic [2*CW-1:0] pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic signed [DFW-1:0] dax2_ff, day2_ff, dbx2_ff, dby2_ff;

   // stage 3: determinant and cross terms
   logic signed [DW-1:0]  den3_ff;
   logic signed [CAW-1:0] ca3_ff, cb3_ff;
   logic signed [DFW-1:0] dax3_ff, day3_ff, dbx3_ff, dby3_ff;

   // stage 4: numerator products
   logic signed [NW-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [DW-1:0] den4_ff;

   // stage 5: numerators
   logic signed [NW-1:0] nx5_ff, ny5_ff;
   logic signed [DW-1:0] den5_ff;

   // stage 6: sign normalized
   logic signed [NW-1:0] nx6_ff, ny6_ff;
   logic [DMW-1:0]       dn6_ff;
   logic                 zero6_ff;

   // stage 7: bound products
   logic [BW-1:0]        bp7_ff [8];
   logic signed [NW-1:0] nx7_ff, ny7_ff;
   logic [DMW-1:0]       dn7_ff;
   logic                 zero7_ff;

   // stage 8: division setup
   div_stage_type stage_ff;

   logic signed [DW-1:0] den_neg;
   logic signed [NW-1:0] nx_fix, ny_fix;
   logic [BW-1:0]        bp_in [8];
   logic                 in_range;
   logic [NW-2:0]        magx, magy;
   logic [RW-1:0]        smx, smy, dfull;

   always_comb begin
      bnd_in[0] = (x1_ff < x2_ff) ? x1_ff : x2_ff;
      bnd_in[1] = (x1_ff > x2_ff) ? x1_ff : x2_ff;
      bnd_in[2] = (x3_ff < x4_ff) ? x3_ff : x4_ff;
      bnd_in[3] = (x3_ff > x4_ff) ? x3_ff : x4_ff;
      bnd_in[4] = (y1_ff < y2_ff) ? y1_ff : y2_ff;
      bnd_in[5] = (y1_ff > y2_ff) ? y1_ff : y2_ff;
      bnd_in[6] = (y3_ff < y4_ff) ? y3_ff : y4_ff;
      bnd_in[7] = (y3_ff > y4_ff) ? y3_ff : y4_ff;
   end

   assign den_neg = -den5_ff;
   assign nx_fix  = den5_ff[DW-1] ? -nx5_ff : nx5_ff;
   assign ny_fix  = den5_ff[DW-1] ? -ny5_ff : ny5_ff;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         bp_in[k] = BW'(bnd6_ff[k]) * BW'(dn6_ff);
      end
   end

   always_comb begin
      in_range = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (k % 2 == 0) begin
            if (nx7_ff < $signed({1'b0, bp7_ff[k]})) in_range = 1'b0;
            if (ny7_ff < $signed({1'b0, bp7_ff[k+4]})) in_range = 1'b0;
         end else begin
            if (nx7_ff > $signed({1'b0, bp7_ff[k]})) in_range = 1'b0;
            if (ny7_ff > $signed({1'b0, bp7_ff[k+4]})) in_range = 1'b0;
         end
      end
   end

   assign magx  = nx7_ff[NW-1] ? (NW-1)'(-nx7_ff) : nx7_ff[NW-2:0];
   assign magy  = ny7_ff[NW-1] ? (NW-1)'(-ny7_ff) : ny7_ff[NW-2:0];
   assign smx   = RW'(magx) << FRAC_BITS;
   assign smy   = RW'(magy) << FRAC_BITS;
   assign dfull = RW'(dn7_ff) << QW;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
         stage_ff.valid <= valid_ff[NS-1];
      end
      if (en) begin
         x1_ff <= x1; y1_ff <= y1; x2_ff <= x2; y2_ff <= y2;
         x3_ff <= x3; y3_ff <= y3; x4_ff <= x4; y4_ff <= y4;
         dax1_ff <= $signed({1'b0, x1}) - $signed({1'b0, x2});
         day1_ff <= $signed({1'b0, y1}) - $signed({1'b0, y2});
         dbx1_ff <= $signed({1'b0, x3}) - $signed({1'b0, x4});
         dby1_ff <= $signed({1'b0, y3}) - $signed({1'b0, y4});

         pd1_ff <= CAW'(dax1_ff) * CAW'(dby1_ff);
         pd2_ff <= CAW'(day1_ff) * CAW'(dbx1_ff);
         pa1_ff <= (2*CW)'(x1_ff) * (2*CW)'(y2_ff);
         pa2_ff <= (2*CW)'(y1_ff) * (2*CW)'(x2_ff);
         pb1_ff <= (2*CW)'(x3_ff) * (2*CW)'(y4_ff);
         pb2_ff <= (2*CW)'(y3_ff) * (2*CW)'(x4_ff);
         dax2_ff <= dax1_ff; day2_ff <= day1_ff;
         dbx2_ff <= dbx1_ff; dby2_ff <= dby1_ff;
         bnd2_ff <= bnd_in;

         den3_ff <= DW'(pd1_ff) - DW'(pd2_ff);
         ca3_ff  <= $signed({2'b00, pa1_ff}) - $signed({2'b00, pa2_ff});
         cb3_ff  <= $signed({2'b00, pb1_ff}) - $signed({2'b00, pb2_ff});
         dax3_ff <= dax2_ff; day3_ff <= day2_ff;
         dbx3_ff <= dbx2_ff; dby3_ff <= dby2_ff;
         bnd3_ff <= bnd2_ff;

         m1_ff <= NW'(ca3_ff) * NW'(dbx3_ff);
         m2_ff <= NW'(dax3_ff) * NW'(cb3_ff);
         m3_ff <= NW'(ca3_ff) * NW'(dby3_ff);
         m4_ff <= NW'(day3_ff) * NW'(cb3_ff);
         den4_ff <= den3_ff;
         bnd4_ff <= bnd3_ff;

         nx5_ff  <= m1_ff - m2_ff;
         ny5_ff  <= m3_ff - m4_ff;
         den5_ff <= den4_ff;
         bnd5_ff <= bnd4_ff;

         nx6_ff   <= nx_fix;
         ny6_ff   <= ny_fix;
         dn6_ff   <= den5_ff[DW-1] ? den_neg[DMW-1:0] : den5_ff[DMW-1:0];
         zero6_ff <= (den5_ff == '0);
         bnd6_ff  <= bnd5_ff;

         bp7_ff   <= bp_in;
         nx7_ff   <= nx6_ff;
         ny7_ff   <= ny6_ff;
         dn7_ff   <= dn6_ff;
         zero7_ff <= zero6_ff;

         stage_ff.outcome <= zero7_ff ? OUTCOME_PARALLEL
                           : (in_range ? OUTCOME_HIT : OUTCOME_MISS);
         stage_ff.dsh    <= RW'(dn7_ff) << (QW - 1);
         stage_ff.x.rem  <= smx;
         stage_ff.x.quot <= '0;
         stage_ff.x.neg  <= nx7_ff[NW-1];
         stage_ff.x.ovf  <= (smx >= dfull);
         stage_ff.y.rem  <= smy;
         stage_ff.y.quot <= '0;
         stage_ff.y.neg  <= ny7_ff[NW-1];
         stage_ff.y.ovf  <= (smy >= dfull);
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

/* src/si_div_cell.sv */
`default_nettype none
module si_div_cell
   import si_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  div_stage_type stage_in,
   output div_stage_type stage_out
);

   div_stage_type stage_ff;
   div_stage_type next_in;
   logic          gex, gey;

   // one restoring step per lane, divisor slides right one bit per cell
   always_comb begin
      next_in = stage_in;
      gex = (stage_in.x.rem >= stage_in.dsh);
      gey = (stage_in.y.rem >= stage_in.dsh);
      if (gex) next_in.x.rem = stage_in.x.rem - stage_in.dsh;
      if (gey) next_in.y.rem = stage_in.y.rem - stage_in.dsh;
      next_in.x.quot = {stage_in.x.quot[QW-2:0], gex};
      next_in.y.quot = {stage_in.y.quot[QW-2:0], gey};
      next_in.dsh    = stage_in.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= next_in.valid;
      end
      if (en) begin
         stage_ff.outcome <= next_in.outcome;
         stage_ff.dsh     <= next_in.dsh;
         stage_ff.x       <= next_in.x;
         stage_ff.y       <= next_in.y;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

/* src/segment_intersection_core.sv */
`default_nettype none
// Segment intersection core: takes two segments as integer pixel endpoints and
// returns the crossing point of their lines as signed fixed point with
// FRAC_BITS fraction bits (truncated toward zero, saturated to 24 bits) plus an
// outcome: hit inside both segments, parallel (point reported as zero), or
// crossing outside. The core takes one segment pair per clock while the result
// register is empty or being taken, and keeps up to 33 pairs in flight: 8
// stages of products and exact bound checks, then a row of 24 divider cells
// (one quotient bit each, both coordinates side by side), then the result
// register. The whole pipeline advances whenever the result register is empty
// or being taken.
module segment_intersection_core
   import si_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CW-1:0]        req_a_start_x,
   input  wire logic [CW-1:0]        req_a_start_y,
   input  wire logic [CW-1:0]        req_a_end_x,
   input  wire logic [CW-1:0]        req_a_end_y,
   input  wire logic [CW-1:0]        req_b_start_x,
   input  wire logic [CW-1:0]        req_b_start_y,
   input  wire logic [CW-1:0]        req_b_end_x,
   input  wire logic [CW-1:0]        req_b_end_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_outcome,
   output logic signed [OUT_W-1:0]   rsp_cross_x,
   output logic signed [OUT_W-1:0]   rsp_cross_y
);

   logic          en;
   div_stage_type chain [QW+1];

   logic              rsp_valid_ff;
   outcome_type       outcome_ff;
   logic [OUT_W-1:0]  cross_x_ff, cross_y_ff;
   logic [OUT_W-1:0]  cross_x_in, cross_y_in;

   function automatic logic [OUT_W-1:0] sat_quot(input lane_type l);
      logic [OUT_W-1:0] r;
      if (l.ovf) begin
         r = l.neg ? OUT_MIN : OUT_MAX;
      end else if (!l.neg) begin
         r = l.quot[QW-1] ? OUT_MAX : l.quot;
      end else begin
         r = (l.quot > OUT_MIN) ? OUT_MIN : -l.quot;
      end
      return r;
   endfunction

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   si_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .x1        (req_a_start_x),
      .y1        (req_a_start_y),
      .x2        (req_a_end_x),
      .y2        (req_a_end_y),
      .x3        (req_b_start_x),
      .y3        (req_b_start_y),
      .x4        (req_b_end_x),
      .y4        (req_b_end_y),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_cell
      si_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // parallel lines report a zero point
   assign cross_x_in = (chain[QW].outcome == OUTCOME_PARALLEL) ? '0 : sat_quot(chain[QW].x);
   assign cross_y_in = (chain[QW].outcome == OUTCOME_PARALLEL) ? '0 : sat_quot(chain[QW].y);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain[QW].valid;
      end
      if (en) begin
         outcome_ff <= chain[QW].outcome;
         cross_x_ff <= cross_x_in;
         cross_y_ff <= cross_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = outcome_ff;
   assign rsp_cross_x = cross_x_ff;
   assign rsp_cross_y = cross_y_ff;

endmodule
`default_nettype wire

/* sim/tb_segment_intersection_core.sv */
`timescale 1ns / 1ps
`default_nettype none

class crossing_scoreboard;
   typedef struct packed {
      logic [1:0]  outcome;
      logic [23:0] cx;
      logic [23:0] cy;
   } crossing_type;

   crossing_type pending_q[$];
   int           mismatches = 0;

   static function logic [23:0] fixed_div(longint num, longint den);
      longint q;
      q = (num * (64'sd1 <<< si_pkg::FRAC_BITS)) / den;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[23:0];
   endfunction

   function void note_request(logic [11:0] p[8]);
      longint x1, y1, x2, y2, x3, y3, x4, y4;
      longint dax, day, dbx, dby, den, ca, cb, nx, ny;
      bit hit;
      crossing_type e;
      x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3];
      x3 = p[4]; y3 = p[5]; x4 = p[6]; y4 = p[7];
      dax = x1 - x2; day = y1 - y2; dbx = x3 - x4; dby = y3 - y4;
      den = dax * dby - day * dbx;
      if (den == 0) begin
         e = '{si_pkg::OUTCOME_PARALLEL, 24'd0, 24'd0};
      end else begin
         ca = x1 * y2 - y1 * x2;
         cb = x3 * y4 - y3 * x4;
         nx = ca * dbx - dax * cb;
         ny = ca * dby - day * cb;
         if (den < 0) begin
            den = -den; nx = -nx; ny = -ny;
         end
         hit = nx >= ((x1 < x2) ? x1 : x2) * den && nx <= ((x1 > x2) ? x1 : x2) * den &&
               nx >= ((x3 < x4) ? x3 : x4) * den && nx <= ((x3 > x4) ? x3 : x4) * den &&
               ny >= ((y1 < y2) ? y1 : y2) * den && ny <= ((y1 > y2) ? y1 : y2) * den &&
               ny >= ((y3 < y4) ? y3 : y4) * den && ny <= ((y3 > y4) ? y3 : y4) * den;
         e.outcome = hit ? si_pkg::OUTCOME_HIT : si_pkg::OUTCOME_MISS;
         e.cx = fixed_div(nx, den);
         e.cy = fixed_div(ny, den);
      end
      pending_q.push_back(e);
   endfunction

   function void check_result(logic [1:0] oc, logic [23:0] cx, logic [23:0] cy);
      crossing_type e;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %0d %h %h", oc, cx, cy);
         return;
      end
      e = pending_q.pop_front();
      if (e.outcome !== oc || e.cx !== cx || e.cy !== cy) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %0d %h %h, got %0d %h %h",
                     e.outcome, e.cx, e.cy, oc, cx, cy);
      end
   endfunction
endclass

module tb_segment_intersection_core;
   import si_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic rsp_ready = 0;
   logic [CW-1:0] req_a_start_x = 0, req_a_start_y = 0, req_a_end_x = 0, req_a_end_y = 0;
   logic [CW-1:0] req_b_start_x = 0, req_b_start_y = 0, req_b_end_x = 0, req_b_end_y = 0;
   logic req_ready, rsp_valid;
   logic [1:0] rsp_outcome;
   logic signed [OUT_W-1:0] rsp_cross_x, rsp_cross_y;

   crossing_scoreboard board = new();
   bit calm = 0;
   int idle_cycles = 0;

   always #6 clock = ~clock;

   segment_intersection_core DUT (.*);

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= calm || ($urandom_range(99) >= 6);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_outcome, rsp_cross_x, rsp_cross_y);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_pair(logic [11:0] p[8]);
      while (!calm && $urandom_range(99) < 6) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_a_start_x <= p[0]; req_a_start_y <= p[1]; req_a_end_x <= p[2]; req_a_end_y <= p[3];
      req_b_start_x <= p[4]; req_b_start_y <= p[5]; req_b_end_x <= p[6]; req_b_end_y <= p[7];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(p);
   endtask

   task automatic send_segments(int ax1, int ay1, int ax2, int ay2,
                                int bx1, int by1, int bx2, int by2);
      logic [11:0] p[8];
      p = '{12'(ax1), 12'(ay1), 12'(ax2), 12'(ay2),
            12'(bx1), 12'(by1), 12'(bx2), 12'(by2)};
      send_pair(p);
   endtask

   function automatic logic [11:0] rand_coord(int span);
      int r;
      r = $urandom_range(9);
      if (r == 0) return 12'd0;
      if (r == 1) return 12'hFFF;
      return 12'($urandom_range(span));
   endfunction

   initial begin
      logic [11:0] p[8];
      int k, m, span;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: crossing, parallel, collinear, zero length, miss, extremes
      send_segments(0, 0, 4095, 4095, 0, 4095, 4095, 0);
      send_segments(0, 0, 10, 0, 0, 5, 10, 5);
      send_segments(0, 0, 10, 10, 20, 20, 30, 30);
      send_segments(7, 7, 7, 7, 0, 0, 100, 3);
      send_segments(0, 0, 1, 1, 100, 0, 99, 1);
      send_segments(0, 0, 10, 0, 10, 0, 10, 10);
      send_segments(0, 0, 10, 0, 5, 1, 5, 20);
      send_segments(4095, 4095, 4095, 0, 0, 4095, 4094, 4095);
      send_segments(0, 0, 1, 4095, 4095, 0, 4094, 4095);
      send_segments(0, 0, 4095, 1, 0, 1, 4095, 0);
      send_segments(0, 1, 1, 0, 4095, 4094, 4094, 4095);
      send_segments(0, 0, 4095, 0, 0, 4095, 4095, 4095);
      send_segments(4095, 0, 0, 4095, 4095, 4095, 0, 0);
      send_segments(3, 0, 3, 9, 0, 3, 9, 3);
      send_segments(0, 0, 1, 2, 4095, 0, 4094, 1);
      send_segments(1, 0, 0, 4095, 4095, 1, 0, 0);
      for (k = 0; k < 1450; k++) begin
         calm = (k >= 600 && k < 800);
         m = $urandom_range(9);
         span = (m < 5) ? 4095 : 63;
         foreach (p[i]) p[i] = rand_coord(span);
         if (m == 8) begin
            // parallel pair with a shared direction
            p[6] = p[4] + p[2] - p[0];
            p[7] = p[5] + p[3] - p[1];
         end else if (m == 9) begin
            p[6] = p[4]; p[7] = p[5];
         end
         send_pair(p);
      end
      req_valid <= 0;
      calm = 1;
      k = 0;
      while (board.pending_q.size() != 0 && k < 20000) begin
         @(posedge clock);
         k++;
      end
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

`default_nettype wire
